/* hdl/periodic_priority_task_scheduler_macros.svh */
// Assertion macros shared by the scheduler checker.
// Depends on nothing; included by the checker file.
`ifndef PERIODIC_PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PERIODIC_PRIORITY_TASK_SCHEDULER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PPTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define PPTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/ppts_pkg.sv */
// Types and codes for the periodic priority task scheduler.
// Depends on nothing.
`default_nettype none
package ppts_pkg;
    localparam int KIND_W = 3;
    localparam int ID_W = 3;
    localparam int PRIO_W = 8;
    localparam int PER_W = 16;
    localparam int STAT_W = 2;
    localparam int OUT_TIME_W = 32;

    typedef enum logic [KIND_W-1:0] {
        K_TICK = 3'd0, K_CREATE = 3'd1, K_SUSPEND = 3'd2, K_RESUME = 3'd3,
        K_SET_PRIO = 3'd4, K_SET_PER = 3'd5, K_DISPATCH = 3'd6, K_NONE = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_SUSPENDED = 2'd0, ST_READY = 2'd1, ST_BLOCKED = 2'd2, ST_SPARE = 2'd3
    } t_tstate;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK = 2'd0, STAT_FULL = 2'd1, STAT_BAD_ID = 2'd2, STAT_NONE = 2'd3
    } t_status;

    // Handshake between sequencer and remainder unit.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_mod_ctl;
endpackage
`default_nettype wire

/* hdl/ppts_ram.sv */
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module ppts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read one entry per cycle, writing it too when i_we is set
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* hdl/ppts_mod.sv */
// Shared restoring remainder unit: time modulo a 16-bit period, one bit a cycle.
// Depends on ppts_pkg.
`default_nettype none
module ppts_mod
    import ppts_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [TIME_BITS-1:0] i_dividend,
    input  wire logic [PER_W-1:0]     i_divisor,
    output logic                      o_busy,
    output logic                      o_done,
    output logic                      o_zero
);
    localparam int CNT_W = $clog2(TIME_BITS + 1);

    logic [TIME_BITS-1:0] r_num;
    logic [PER_W:0]       r_rem;
    logic [PER_W-1:0]     r_div;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [PER_W:0]       n_shift;
    logic [PER_W:0]       n_diff;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        n_shift = {r_rem[PER_W-1:0], r_num[TIME_BITS-1]};
        n_diff  = n_shift - {1'b0, r_div};
    end

    // Step one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(TIME_BITS);
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= n_diff[PER_W] ? n_shift : n_diff;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_zero = (r_rem == '0);
endmodule
`default_nettype wire

/* hdl/periodic_priority_task_scheduler.sv */
// Periodic fixed-priority task scheduler: one request in, one response out.
// A tick reads each created task's period and runs it through the bit-serial
// remainder unit; dispatch reads and compares each created task in a table walk;
// every request then passes S_OUT to update the table and S_RESP to load the
// response register, which holds the response until the sink takes it while the
// next request is already accepted. Depends on ppts_pkg, ppts_ram, ppts_mod.
`default_nettype none
module periodic_priority_task_scheduler
    import ppts_pkg::*;
#(
    parameter int MAX_TASKS = 8,
    parameter int TIME_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: task_id[2:0], priority_req[10:3], period[26:11], zero fill to 31
    input  wire logic [31:0] s_axis_tdata,
    // tuser: kind[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: status[1:0], granted_id[4:2], current_time[36:5], any_ready[37], zero to 39
    output logic [39:0]      m_axis_tdata
);
    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_TICK_RD, S_TICK_MOD, S_TICK_WAIT, S_DSP_RD, S_DSP_CMP, S_OUT, S_RESP
    } t_seq;

    t_seq                 r_state;
    t_kind                r_kind;
    logic [ID_W-1:0]      r_id;
    logic [PRIO_W-1:0]    r_prio_in;
    logic [PER_W-1:0]     r_per_in;
    t_tstate              r_tst [MAX_TASKS];
    logic [CNT_W-1:0]     r_count;
    logic [TIME_BITS-1:0] r_time;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best;
    logic [PRIO_W-1:0]    r_best_prio;
    logic [STAT_W-1:0]    r_status;
    logic [ID_W-1:0]      r_granted;
    logic                 r_ovalid;
    logic [39:0]          r_odata;

    logic                 n_prio_we;
    logic                 n_per_we;
    logic [IDX_W-1:0]     n_addr;
    logic [PRIO_W-1:0]    w_prio_rd;
    logic [PER_W-1:0]     w_per_rd;
    logic                 n_any;
    logic                 w_id_ok;
    logic                 w_last;
    t_mod_ctl             w_mod;

    // Request id as a table index, checked against the fill count
    assign w_id_ok = ({{(CNT_W > ID_W ? CNT_W - ID_W : 0){1'b0}}, r_id} < r_count);
    assign w_last  = ({1'b0, r_idx} + 1'b1) >= {1'b0, r_count};

    // Drive memory ports from the sequencer
    always_comb begin
        n_prio_we = 1'b0;
        n_per_we  = 1'b0;
        n_addr    = r_idx;
        if (r_state == S_IDLE || r_state == S_OUT) begin
            n_addr = r_idx;
        end
        case (r_state)
            S_TICK_RD, S_DSP_RD: n_addr = r_idx;
            default: n_addr = r_idx;
        endcase
        if (r_state == S_IDLE) begin
            n_addr = r_idx;
        end
        // Writes issue in the update cycle for the request stored in r_kind
        if (r_state == S_OUT) begin
            case (r_kind)
                K_CREATE: begin
                    n_prio_we = (r_status == STAT_OK);
                    n_per_we  = (r_status == STAT_OK);
                end
                K_SET_PRIO: n_prio_we = w_id_ok;
                K_SET_PER:  n_per_we  = w_id_ok;
                default: ;
            endcase
        end
    end

    ppts_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_prio (
        .i_clk(i_clk), .i_we(n_prio_we), .i_addr(n_addr),
        .i_wdata(r_prio_in), .o_rdata(w_prio_rd)
    );
    ppts_ram #(.WIDTH(PER_W), .DEPTH(MAX_TASKS)) u_per (
        .i_clk(i_clk), .i_we(n_per_we), .i_addr(n_addr),
        .i_wdata(r_per_in), .o_rdata(w_per_rd)
    );

    logic w_mod_zero;
    assign w_mod.start = (r_state == S_TICK_MOD);
    ppts_mod #(.TIME_BITS(TIME_BITS)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mod.start),
        .i_dividend(r_time), .i_divisor(w_per_rd),
        .o_busy(w_mod.busy), .o_done(w_mod.done), .o_zero(w_mod_zero)
    );

    // Any ready task among created ones
    always_comb begin
        n_any = 1'b0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (CNT_W'(i) < r_count && r_tst[i] == ST_READY) begin
                n_any = 1'b1;
            end
        end
    end

    // Sequencer, task table and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_time   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_tst[i] <= ST_SUSPENDED;
            end
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_RESP) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind    <= t_kind'(s_axis_tuser);
                        r_id      <= s_axis_tdata[2:0];
                        r_prio_in <= s_axis_tdata[10:3];
                        r_per_in  <= s_axis_tdata[26:11];
                        r_status  <= STAT_OK;
                        r_granted <= '0;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_state   <= S_OUT;
                        case (t_kind'(s_axis_tuser))
                            K_TICK: begin
                                r_time  <= r_time + 1'b1;
                                r_state <= (r_count == '0) ? S_OUT : S_TICK_RD;
                            end
                            K_CREATE: begin
                                if (r_count >= CNT_W'(MAX_TASKS)) begin
                                    r_status <= STAT_FULL;
                                end else begin
                                    r_idx     <= r_count[IDX_W-1:0];
                                    r_granted <= ID_W'(r_count);
                                end
                            end
                            K_SUSPEND, K_RESUME, K_SET_PRIO, K_SET_PER: begin
                                r_idx <= IDX_W'(s_axis_tdata[2:0]);
                            end
                            K_DISPATCH: begin
                                if (r_count == '0) begin
                                    r_status <= STAT_NONE;
                                end else begin
                                    r_state <= S_DSP_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_TICK_RD: r_state <= S_TICK_MOD;
                S_TICK_MOD: r_state <= S_TICK_WAIT;
                S_TICK_WAIT: begin
                    if (w_mod.done && !w_mod.busy) begin
                        if (w_per_rd != '0 && r_tst[r_idx] != ST_SUSPENDED && w_mod_zero) begin
                            r_tst[r_idx] <= ST_READY;
                        end
                        if (w_last) begin
                            r_state <= S_OUT;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_TICK_RD;
                        end
                    end
                end
                S_DSP_RD: r_state <= S_DSP_CMP;
                S_DSP_CMP: begin
                    logic w_take;
                    w_take = (r_tst[r_idx] == ST_READY) && (!r_found || w_prio_rd < r_best_prio);
                    if (w_take) begin
                        r_found     <= 1'b1;
                        r_best      <= r_idx;
                        r_best_prio <= w_prio_rd;
                    end
                    if (w_last) begin
                        if (w_take) begin
                            r_tst[r_idx] <= ST_BLOCKED;
                            r_granted    <= ID_W'(r_idx);
                        end else if (r_found) begin
                            r_tst[r_best] <= ST_BLOCKED;
                            r_granted     <= ID_W'(r_best);
                        end else begin
                            r_status <= STAT_NONE;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_DSP_RD;
                    end
                end
                S_OUT: begin
                    case (r_kind)
                        K_CREATE: begin
                            if (r_status == STAT_OK) begin
                                r_tst[r_idx] <= ST_READY;
                                r_count      <= r_count + 1'b1;
                            end
                        end
                        K_SUSPEND: begin
                            if (w_id_ok) r_tst[r_idx] <= ST_SUSPENDED;
                        end
                        K_RESUME: begin
                            if (w_id_ok) r_tst[r_idx] <= ST_BLOCKED;
                        end
                        default: ;
                    endcase
                    if ((r_kind == K_SUSPEND || r_kind == K_RESUME ||
                         r_kind == K_SET_PRIO || r_kind == K_SET_PER) && !w_id_ok) begin
                        r_status <= STAT_BAD_ID;
                    end
                    r_state <= S_RESP;
                end
                // Load the response once the previous one has left
                S_RESP: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= {2'b00, n_any, OUT_TIME_W'(r_time), r_granted, r_status};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule
`default_nettype wire

/* hdl/ppts_checker.sv */
// Port-level checker for the scheduler, bound to the top level.
// Depends on ppts_pkg and the assertion macro header.
`default_nettype none
`include "periodic_priority_task_scheduler_macros.svh"
module ppts_checker
    import ppts_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    // Handshake outputs are always known
    `PPTS_ASSERT_IMP(a_ctl_known, i_clk, i_rst_n, 1'b1, !$isunknown({m_axis_tvalid, s_axis_tready}))
    // A presented response carries known data
    `PPTS_ASSERT_IMP(a_resp_known, i_clk, i_rst_n, m_axis_tvalid, !$isunknown(m_axis_tdata))
    // Accepted request blocks further acceptance next cycle
    `PPTS_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Stalled response holds
    `PPTS_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
bind periodic_priority_task_scheduler ppts_checker u_chk (.*);
`default_nettype wire

/* tb/periodic_priority_task_scheduler_tb.sv */
// Self-checking testbench for the periodic priority task scheduler.
// Predicts each response from a local copy of the task table and compares it
// field by field. Depends on ppts_pkg and the scheduler RTL.
`default_nettype none
module periodic_priority_task_scheduler_tb;
    import ppts_pkg::*;

    localparam int NTASK = 8;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        any_ready;
        logic [31:0] current_time;
        logic [2:0]  granted_id;
        t_status     status;
    } t_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    // Scheduler shadow state
    logic [7:0]  sh_prio [NTASK];
    logic [15:0] sh_per [NTASK];
    t_tstate     sh_state [NTASK];
    int          sh_count;
    logic [31:0] sh_time;

    t_resp expected_resp_q[$];
    int    fail_count;
    int    cycle_count;

    periodic_priority_task_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the shadow table and return the expected response
    function automatic t_resp schedule_request(t_kind kind, logic [2:0] id,
                                               logic [7:0] prio, logic [15:0] per);
        t_resp r;
        int    best;
        r.status = STAT_OK;
        r.granted_id = 3'd0;
        best = -1;
        case (kind)
            K_TICK: begin
                sh_time = sh_time + 1;
                for (int i = 0; i < sh_count; i++)
                    if (sh_per[i] != 0 && sh_state[i] != ST_SUSPENDED &&
                        sh_time % sh_per[i] == 0)
                        sh_state[i] = ST_READY;
            end
            K_CREATE: begin
                if (sh_count >= NTASK) begin
                    r.status = STAT_FULL;
                end else begin
                    sh_prio[sh_count] = prio;
                    sh_per[sh_count] = per;
                    sh_state[sh_count] = ST_READY;
                    r.granted_id = sh_count[2:0];
                    sh_count++;
                end
            end
            K_SUSPEND, K_RESUME, K_SET_PRIO, K_SET_PER: begin
                if (int'(id) >= sh_count) r.status = STAT_BAD_ID;
                else if (kind == K_SUSPEND) sh_state[id] = ST_SUSPENDED;
                else if (kind == K_RESUME) sh_state[id] = ST_BLOCKED;
                else if (kind == K_SET_PRIO) sh_prio[id] = prio;
                else sh_per[id] = per;
            end
            K_DISPATCH: begin
                for (int i = 0; i < sh_count; i++)
                    if (sh_state[i] == ST_READY && (best < 0 || sh_prio[i] < sh_prio[best]))
                        best = i;
                if (best >= 0) begin
                    sh_state[best] = ST_BLOCKED;
                    r.granted_id = best[2:0];
                end else begin
                    r.status = STAT_NONE;
                end
            end
            default: ;
        endcase
        r.current_time = sh_time;
        r.any_ready = 1'b0;
        for (int i = 0; i < sh_count; i++)
            if (sh_state[i] == ST_READY) r.any_ready = 1'b1;
        return r;
    endfunction

    // Send one request after a random gap and record its expected response
    task automatic send_request(t_kind kind, logic [2:0] id, logic [7:0] prio,
                                logic [15:0] per);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= $urandom & 32'h07ff_ffff;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {5'd0, per, prio, id};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        expected_resp_q.push_back(schedule_request(kind, id, prio, per));
    endtask

    // Drain the response stream against the expected queue
    initial begin
        t_resp got;
        t_resp want;
        int    wait_n;
        m_axis_tready = 1'b0;
        forever begin
            wait_n = $urandom_range(0, 8);
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            got = m_axis_tdata[37:0];
            if (expected_resp_q.size() == 0) begin
                $display("%0t: unexpected response %h", $time, got);
                fail_count++;
            end else begin
                want = expected_resp_q.pop_front();
                if (got.status != want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    fail_count++;
                end
                if (got.granted_id != want.granted_id) begin
                    $display("%0t: granted_id exp %0d got %0d", $time,
                             want.granted_id, got.granted_id);
                    fail_count++;
                end
                if (got.current_time != want.current_time) begin
                    $display("%0t: current_time exp %0d got %0d", $time,
                             want.current_time, got.current_time);
                    fail_count++;
                end
                if (got.any_ready != want.any_ready) begin
                    $display("%0t: any_ready exp %0d got %0d", $time,
                             want.any_ready, got.any_ready);
                    fail_count++;
                end
            end
        end
    end

    // Abort on a hung run
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("periodic_priority_task_scheduler test failed");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_request(K_DISPATCH, 3'd0, 8'd0, 16'd0);
        send_request(K_SUSPEND, 3'd0, 8'd0, 16'd0);
        send_request(K_NONE, 3'd7, 8'hff, 16'hffff);
        send_request(K_CREATE, 3'd7, 8'hff, 16'd0);
        send_request(K_CREATE, 3'd0, 8'd0, 16'd1);
        send_request(K_CREATE, 3'd0, 8'hff, 16'hffff);
        send_request(K_CREATE, 3'd0, 8'd5, 16'd2);
        send_request(K_DISPATCH, 3'd0, 8'd0, 16'd0);
        send_request(K_DISPATCH, 3'd0, 8'd0, 16'd0);
        send_request(K_DISPATCH, 3'd0, 8'd0, 16'd0);
        send_request(K_DISPATCH, 3'd0, 8'd0, 16'd0);
        send_request(K_DISPATCH, 3'd0, 8'd0, 16'd0);
        send_request(K_TICK, 3'd0, 8'd0, 16'd0);
        send_request(K_TICK, 3'd0, 8'd0, 16'd0);
        send_request(K_SUSPEND, 3'd1, 8'd0, 16'd0);
        send_request(K_SET_PRIO, 3'd1, 8'd0, 16'd0);
        send_request(K_SET_PER, 3'd1, 8'd0, 16'd3);
        send_request(K_RESUME, 3'd1, 8'd0, 16'd0);
        send_request(K_SET_PRIO, 3'd5, 8'd1, 16'd0);
        for (int i = 0; i < 5; i++) send_request(K_CREATE, 3'd0, 8'd7, 16'd4);
        send_request(K_CREATE, 3'd0, 8'd7, 16'd4);
    endtask

    // Random mix weighted toward ticks and dispatches on a populated table
    task automatic test_random(int n);
        t_kind k;
        int    sel;
        logic [15:0] per;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) k = K_TICK;
            else if (sel < 38) k = K_CREATE;
            else if (sel < 48) k = K_SUSPEND;
            else if (sel < 58) k = K_RESUME;
            else if (sel < 66) k = K_SET_PRIO;
            else if (sel < 74) k = K_SET_PER;
            else if (sel < 97) k = K_DISPATCH;
            else k = K_NONE;
            per = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
            send_request(k, 3'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom)
                         : 8'($urandom_range(0, 3)), per);
        end
    endtask

    initial begin
        fail_count = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 32'd0;
        s_axis_tuser = 3'd0;
        sh_count = 0;
        sh_time = 32'd0;
        for (int i = 0; i < NTASK; i++) begin
            sh_prio[i] = 8'd0;
            sh_per[i] = 16'd0;
            sh_state[i] = ST_SUSPENDED;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1830);
        s_axis_tvalid <= 1'b0;
        while (expected_resp_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && expected_resp_q.size() == 0)
            $display("periodic_priority_task_scheduler test passed");
        else
            $display("periodic_priority_task_scheduler test failed");
        $finish;
    end
endmodule
`default_nettype wire

/* periodic_priority_task_scheduler.f */
+incdir+hdl
hdl/ppts_pkg.sv
hdl/ppts_ram.sv
hdl/ppts_mod.sv
hdl/periodic_priority_task_scheduler.sv
hdl/ppts_checker.sv
tb/periodic_priority_task_scheduler_tb.sv
